@@ rtl/mcfl_pkg.sv @@
// Package for the MHD CFL time step reduction block.
// Holds field widths, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcfl_pkg;

    localparam int DENS_W  = 31;
    localparam int MOM_W   = 32;
    localparam int ENER_W  = 31;
    localparam int STEP_W  = 31;
    localparam int GAMMA_W = 19;
    localparam int COUR_W  = 17;
    localparam int EPS_W   = 16;
    localparam int CFG_W   = 19;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_GAMMA   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_COURANT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_EPSILON = 2'd2;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET   = 19'd109227;
    localparam logic [COUR_W-1:0]  COURANT_RESET = 17'd45875;
    localparam logic [EPS_W-1:0]   EPSILON_RESET = 16'd1;
    localparam logic [STEP_W-1:0]  STEP_MAX      = 31'h7FFF_FFFF;
    localparam logic [GAMMA_W-1:0] GAMMA_ONE     = 19'd65536;

endpackage
`default_nettype wire

@@ rtl/mhd_cfl_timestep_reduce.sv @@
// Top level of the MHD CFL time step reduction block: sequencer and a shared
// bit-serial multiply / divide / square root unit. Depends on mcfl_pkg.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    eight cell fields, i_last_cell
//   output    out        o_out_valid / i_out_stall  o_time_step
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// After a cell is accepted, the block is ready again once the sequencer has run
// its program on the single shared arithmetic unit, which retires one bit per
// cycle: six 32-step squares, two 32-step products, five 64-step restoring
// divisions and one 40-step square root, each with a load and a post state.
// Reset is synchronous and active low; it restores the register defaults and
// sets the running minimum to its largest value. A finished time step waits in
// the output register, so the next cell is taken while it is stalled; only a
// second final result stalls the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module mhd_cfl_timestep_reduce (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [mcfl_pkg::DENS_W-1:0]    i_density,
    input  wire logic [mcfl_pkg::MOM_W-1:0]     i_momentum_x,
    input  wire logic [mcfl_pkg::MOM_W-1:0]     i_momentum_y,
    input  wire logic [mcfl_pkg::MOM_W-1:0]     i_momentum_z,
    input  wire logic [mcfl_pkg::MOM_W-1:0]     i_field_x,
    input  wire logic [mcfl_pkg::MOM_W-1:0]     i_field_y,
    input  wire logic [mcfl_pkg::MOM_W-1:0]     i_field_z,
    input  wire logic [mcfl_pkg::ENER_W-1:0]    i_total_energy,
    input  wire logic                           i_last_cell,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [mcfl_pkg::STEP_W-1:0]         o_time_step,
    input  wire logic                           i_cfg_we,
    input  wire logic [mcfl_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [mcfl_pkg::CFG_W-1:0]     i_cfg_data
);
    import mcfl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_POST,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    // Sequencer program steps.
    localparam logic [3:0] PC_KIN   = 4'd6;
    localparam logic [3:0] PC_PRESS = 4'd7;
    localparam logic [3:0] PC_GP    = 4'd8;
    localparam logic [3:0] PC_CS2   = 4'd9;
    localparam logic [3:0] PC_CA2   = 4'd10;
    localparam logic [3:0] PC_ROOT  = 4'd11;
    localparam logic [3:0] PC_VEL   = 4'd12;
    localparam logic [3:0] PC_STEP  = 4'd13;

    t_state r_state;
    t_op    r_op;
    logic [3:0]  r_pc;
    logic [6:0]  r_cnt;

    logic [GAMMA_W-1:0] r_gamma;
    logic [COUR_W-1:0]  r_cour;
    logic [EPS_W-1:0]   r_eps;
    logic [STEP_W-1:0]  r_min;

    // Cell operands.
    logic [31:0]        r_mag [6];
    logic [DENS_W-1:0]  r_rho;
    logic [ENER_W-1:0]  r_energy;
    logic               r_last;

    // Intermediate results.
    logic [63:0]        r_m2;
    logic [63:0]        r_b2;
    logic [30:0]        r_internal;
    logic [33:0]        r_press;
    logic [63:0]        r_cs2;
    logic [48:0]        r_speed;
    logic [STEP_W-1:0]  r_step;

    // Shared unit.
    logic [63:0] r_acc;
    logic [48:0] r_mcand;
    logic [31:0] r_mplier;
    logic [49:0] r_rem;
    logic [39:0] r_root;

    logic               r_out_valid;
    logic [STEP_W-1:0]  r_time_step;

    // One bit of each operation.
    logic [63:0] n_mul_acc;
    logic [49:0] n_div_t;
    logic        n_div_q;
    logic [43:0] n_sq_t;
    logic [41:0] n_sq_trial;
    logic        n_sq_bit;
    logic [GAMMA_W-1:0] n_gm1;
    logic [64:0] n_total;
    logic [64:0] n_sum;
    logic [STEP_W-1:0]  n_min;
    logic        n_finish_ok;
    logic        n_emit;

    function automatic logic [31:0] f_mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    assign n_mul_acc  = {r_acc[62:0], 1'b0} + (r_mplier[31] ? {15'd0, r_mcand} : 64'd0);
    assign n_div_t    = {r_rem[48:0], r_acc[63]};
    assign n_div_q    = (n_div_t >= {1'b0, r_mcand});
    assign n_sq_t     = {r_rem[41:0], r_acc[63:62]};
    assign n_sq_trial = {r_root, 2'b01};
    assign n_sq_bit   = (n_sq_t >= {2'b00, n_sq_trial});
    assign n_gm1      = (r_gamma >= GAMMA_ONE) ? (r_gamma - GAMMA_ONE) : '0;
    assign n_total    = {1'b0, r_acc} + {18'd0, r_b2[63:17]};
    assign n_sum      = {1'b0, r_cs2} + {1'b0, r_acc};
    assign n_min      = (r_step < r_min) ? r_step : r_min;
    assign n_finish_ok = !r_last || !r_out_valid || !i_out_stall;
    // A final cell hands its minimum to the output register this cycle.
    assign n_emit     = (r_state == S_FINISH) && n_finish_ok && r_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_time_step = r_time_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_MUL;
            r_pc        <= '0;
            r_cnt       <= '0;
            r_gamma     <= GAMMA_RESET;
            r_cour      <= COURANT_RESET;
            r_eps       <= EPSILON_RESET;
            r_min       <= STEP_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAMMA:   r_gamma <= i_cfg_data[GAMMA_W-1:0];
                    CFG_COURANT: r_cour  <= i_cfg_data[COUR_W-1:0];
                    CFG_EPSILON: r_eps   <= i_cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end

            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mag[0] <= f_mag(i_momentum_x);
                        r_mag[1] <= f_mag(i_momentum_y);
                        r_mag[2] <= f_mag(i_momentum_z);
                        r_mag[3] <= f_mag(i_field_x);
                        r_mag[4] <= f_mag(i_field_y);
                        r_mag[5] <= f_mag(i_field_z);
                        // A zero density is taken as one LSB.
                        r_rho    <= (i_density == '0) ? DENS_W'(1) : i_density;
                        r_energy <= i_total_energy;
                        r_last   <= i_last_cell;
                        r_m2     <= '0;
                        r_b2     <= '0;
                        r_pc     <= '0;
                        r_state  <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_rem   <= '0;
                    // A zero speed saturates the step without dividing.
                    r_state <= (r_pc == PC_STEP && r_speed == '0) ? S_POST : S_RUN;
                    case (r_pc)
                        PC_KIN: begin
                            r_op    <= OP_DIV;
                            r_cnt   <= 7'd64;
                            r_acc   <= r_m2;
                            r_mcand <= {17'd0, r_rho, 1'b0};
                        end
                        PC_PRESS: begin
                            r_op     <= OP_MUL;
                            r_cnt    <= 7'd32;
                            r_acc    <= '0;
                            r_mcand  <= {18'd0, r_internal};
                            r_mplier <= {13'd0, n_gm1};
                        end
                        PC_GP: begin
                            r_op     <= OP_MUL;
                            r_cnt    <= 7'd32;
                            r_acc    <= '0;
                            r_mcand  <= {15'd0, r_press};
                            r_mplier <= {13'd0, r_gamma};
                        end
                        PC_CS2: begin
                            // The dividend is the product left in the accumulator.
                            r_op    <= OP_DIV;
                            r_cnt   <= 7'd64;
                            r_mcand <= {18'd0, r_rho};
                        end
                        PC_CA2: begin
                            r_op    <= OP_DIV;
                            r_cnt   <= 7'd64;
                            r_acc   <= r_b2;
                            r_mcand <= {18'd0, r_rho};
                        end
                        PC_ROOT: begin
                            r_op   <= OP_SQRT;
                            r_cnt  <= 7'd40;
                            r_acc  <= r_cs2;
                            r_root <= '0;
                        end
                        PC_VEL: begin
                            r_op    <= OP_DIV;
                            r_cnt   <= 7'd64;
                            r_acc   <= {16'd0, r_mag[0], 16'd0};
                            r_mcand <= {18'd0, r_rho};
                        end
                        PC_STEP: begin
                            r_op    <= OP_DIV;
                            r_cnt   <= 7'd64;
                            r_mcand <= r_speed;
                            if (r_speed == '0) begin
                                r_acc <= {33'd0, STEP_MAX};
                            end else begin
                                r_acc <= {31'd0, r_cour, 16'd0};
                            end
                        end
                        default: begin
                            // Squares of the momentum and field magnitudes.
                            r_op     <= OP_MUL;
                            r_cnt    <= 7'd32;
                            r_acc    <= '0;
                            r_mcand  <= {17'd0, r_mag[r_pc[2:0]]};
                            r_mplier <= r_mag[r_pc[2:0]];
                        end
                    endcase
                end
                S_RUN: begin
                    case (r_op)
                        OP_MUL: begin
                            r_acc    <= n_mul_acc;
                            r_mplier <= {r_mplier[30:0], 1'b0};
                        end
                        OP_DIV: begin
                            r_acc <= {r_acc[62:0], n_div_q};
                            r_rem <= n_div_q ? (n_div_t - {1'b0, r_mcand}) : n_div_t;
                        end
                        OP_SQRT: begin
                            r_acc  <= {r_acc[61:0], 2'b00};
                            r_root <= {r_root[38:0], n_sq_bit};
                            r_rem  <= {6'd0, n_sq_bit ? (n_sq_t - {2'b00, n_sq_trial})
                                                      : n_sq_t};
                        end
                        default: ;
                    endcase
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_pc    <= r_pc + 4'd1;
                    r_state <= (r_pc == PC_STEP) ? S_FINISH : S_LOAD;
                    case (r_pc)
                        PC_KIN: begin
                            // Internal energy, clamped to zero when negative.
                            if (n_total >= {34'd0, r_energy}) begin
                                r_internal <= '0;
                            end else begin
                                r_internal <= r_energy - n_total[30:0];
                            end
                        end
                        PC_PRESS: r_press <= r_acc[49:16];
                        PC_GP:    ;
                        PC_CS2:   r_cs2 <= r_acc;
                        PC_CA2:   r_cs2 <= n_sum[64] ? '1 : n_sum[63:0];
                        PC_ROOT:  ;
                        PC_VEL: begin
                            r_speed <= r_acc[48:0] + {9'd0, r_root} + {33'd0, r_eps};
                        end
                        PC_STEP: begin
                            r_step  <= (r_acc > {33'd0, STEP_MAX}) ? STEP_MAX : r_acc[30:0];
                        end
                        default: begin
                            if (r_pc < 4'd3) begin
                                r_m2 <= r_m2 + r_acc;
                            end else begin
                                r_b2 <= r_b2 + r_acc;
                            end
                        end
                    endcase
                end
                S_FINISH: begin
                    // A final cell waits here only while an earlier result is unread.
                    if (n_finish_ok) begin
                        if (r_last) begin
                            r_time_step <= n_min;
                            r_min       <= STEP_MAX;
                        end else begin
                            r_min <= n_min;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
